// ----- rtl/core/bgls_pkg.sv -----
// Shared constants, request and outcome codes, and controller-datapath interface types.
package bgls_pkg;

  localparam int MAX_DIM = 4096;
  localparam int ADDR_W  = 12;
  localparam int DIM_W   = 13;
  localparam int OFF_W   = 10;
  localparam int POS_W   = 14;
  localparam int PIX_W   = 8;

  localparam logic [DIM_W-1:0]  DIM_LIMIT = DIM_W'(MAX_DIM);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_DIM - 1);
  localparam logic [PIX_W-1:0]  INK_VALUE = 8'd255;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] OUT_KEPT  = 2'd0;
  localparam logic [1:0] OUT_MOVED = 2'd1;
  localparam logic [1:0] OUT_FAIL  = 2'd2;

  localparam logic [1:0] CFG_SHIFT_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [OFF_W-1:0] RST_SHIFT_LIMIT = 10'd20;

  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic load_px;
    logic q_start;
    logic band_load;
    logic idx_step;
    logic search_start;
    logic next_above;
    logic next_off;
    logic set_kept;
    logic set_moved;
    logic set_fail;
    logic out_load;
  } bgls_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic band_empty;
    logic mark_hit;
    logic scan_last;
    logic phase0;
    logic above;
    logic off_last;
    logic max_zero;
    logic out_free;
  } bgls_status_t;

endpackage

// ----- rtl/core/bgls_ctrl.sv -----
// Controller state machine that sequences clearing, loading and the gap search.
module bgls_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [1:0]               in_req_type,
  output logic                     in_stall,
  input  bgls_pkg::bgls_status_t   status,
  output bgls_pkg::bgls_cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_BAND   = 7'b0000100,
    S_READ   = 7'b0001000,
    S_CHECK  = 7'b0010000,
    S_NEXT   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            bgls_pkg::REQ_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_nxt     = S_CLEAR;
            end
            bgls_pkg::REQ_LOAD: begin
              cmd.load_px = 1'b1;
            end
            bgls_pkg::REQ_QUERY: begin
              cmd.q_start = 1'b1;
              state_nxt   = S_BAND;
            end
            default: begin
            end
          endcase
        end
      end
      S_BAND: begin
        cmd.band_load = 1'b1;
        if (status.band_empty) begin
          if (status.phase0) begin
            cmd.set_kept = 1'b1;
            state_nxt    = S_FINISH;
          end else begin
            state_nxt = S_NEXT;
          end
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (status.mark_hit) begin
          if (status.phase0) begin
            if (status.max_zero) begin
              cmd.set_fail = 1'b1;
              state_nxt    = S_FINISH;
            end else begin
              cmd.search_start = 1'b1;
              state_nxt        = S_BAND;
            end
          end else begin
            state_nxt = S_NEXT;
          end
        end else if (status.scan_last) begin
          cmd.set_kept  = status.phase0;
          cmd.set_moved = !status.phase0;
          state_nxt     = S_FINISH;
        end else begin
          cmd.idx_step = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_NEXT: begin
        priority if (!status.above) begin
          cmd.next_above = 1'b1;
          state_nxt      = S_BAND;
        end else if (status.off_last) begin
          cmd.set_fail = 1'b1;
          state_nxt    = S_FINISH;
        end else begin
          cmd.next_off = 1'b1;
          state_nxt    = S_BAND;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/bgls_datapath.sv -----
// Datapath with configuration registers, row and column mark stores, band scan and result register.
module bgls_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [bgls_pkg::DIM_W-1:0]        cfg_wdata,
  input  logic [bgls_pkg::ADDR_W-1:0]       in_pixel_x,
  input  logic [bgls_pkg::ADDR_W-1:0]       in_pixel_y,
  input  logic [bgls_pkg::PIX_W-1:0]        in_pixel_value,
  input  logic [bgls_pkg::ADDR_W-1:0]       in_target,
  input  logic                              in_horizontal,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bgls_pkg::POS_W-1:0] out_position,
  output logic [1:0]                        out_outcome,
  input  bgls_pkg::bgls_cmd_t               cmd,
  output bgls_pkg::bgls_status_t            status
);

  logic [bgls_pkg::OFF_W-1:0]  shift_limit_r, shift_limit_nxt;
  logic [bgls_pkg::DIM_W-1:0]  width_r, width_nxt;
  logic [bgls_pkg::DIM_W-1:0]  height_r, height_nxt;
  logic [bgls_pkg::ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [bgls_pkg::ADDR_W-1:0] tgt_r, tgt_nxt;
  logic                        horiz_r, horiz_nxt;
  logic                        phase0_r, phase0_nxt;
  logic                        above_r, above_nxt;
  logic [bgls_pkg::OFF_W-1:0]  off_r, off_nxt;
  logic [bgls_pkg::ADDR_W-1:0] idx_r, idx_nxt;
  logic [bgls_pkg::DIM_W-1:0]  hi_r, hi_nxt;
  logic signed [bgls_pkg::POS_W-1:0] res_pos_r, res_pos_nxt;
  logic [1:0]                  res_outcome_r, res_outcome_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [bgls_pkg::POS_W-1:0] out_position_r, out_position_nxt;
  logic [1:0]                  out_outcome_r, out_outcome_nxt;

  logic row_mem [bgls_pkg::MAX_DIM];
  logic col_mem [bgls_pkg::MAX_DIM];
  logic row_rd_r;
  logic col_rd_r;

  logic [bgls_pkg::DIM_W-1:0]  w_clamp;
  logic [bgls_pkg::DIM_W-1:0]  h_clamp;
  logic [bgls_pkg::DIM_W-1:0]  lim;
  logic                        px_ok;
  logic                        row_we, col_we, mem_wd;
  logic [bgls_pkg::ADDR_W-1:0] row_wa, col_wa;
  logic signed [bgls_pkg::POS_W-1:0] tgt_s, off_s, center;
  logic signed [bgls_pkg::POS_W-1:0] lo_raw, hi_raw, lo, hi, lim_s;
  logic                        out_free;

  assign w_clamp = (width_r > bgls_pkg::DIM_LIMIT) ? bgls_pkg::DIM_LIMIT : width_r;
  assign h_clamp = (height_r > bgls_pkg::DIM_LIMIT) ? bgls_pkg::DIM_LIMIT : height_r;
  assign lim     = horiz_r ? h_clamp : w_clamp;

  assign px_ok = cmd.load_px && (in_pixel_value == bgls_pkg::INK_VALUE) &&
                 ({1'b0, in_pixel_x} < w_clamp) && ({1'b0, in_pixel_y} < h_clamp);

  assign row_we = cmd.clr_step || px_ok;
  assign col_we = cmd.clr_step || px_ok;
  assign mem_wd = !cmd.clr_step;
  assign row_wa = cmd.clr_step ? clr_cnt_r : in_pixel_y;
  assign col_wa = cmd.clr_step ? clr_cnt_r : in_pixel_x;

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_wa] <= mem_wd;
    end
    row_rd_r <= row_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_wa] <= mem_wd;
    end
    col_rd_r <= col_mem[idx_r];
  end

  assign tgt_s  = $signed({2'b00, tgt_r});
  assign off_s  = $signed({4'b0000, off_r});
  assign center = phase0_r ? tgt_s : (above_r ? tgt_s + off_s : tgt_s - off_s);
  assign lo_raw = center - 14'sd2;
  assign hi_raw = center + 14'sd3;
  assign lim_s  = $signed({1'b0, lim});
  assign lo     = lo_raw[bgls_pkg::POS_W-1] ? '0 : lo_raw;
  assign hi     = (hi_raw > lim_s) ? lim_s : hi_raw;

  assign out_free = !out_valid_r || !out_stall;

  assign status.clr_last   = (clr_cnt_r == bgls_pkg::ADDR_LAST);
  assign status.band_empty = (hi <= lo);
  assign status.mark_hit   = horiz_r ? row_rd_r : col_rd_r;
  assign status.scan_last  = (({1'b0, idx_r} + 13'd1) == hi_r);
  assign status.phase0     = phase0_r;
  assign status.above      = above_r;
  assign status.off_last   = (off_r == shift_limit_r);
  assign status.max_zero   = (shift_limit_r == '0);
  assign status.out_free   = out_free;

  always_comb begin
    shift_limit_nxt  = shift_limit_r;
    width_nxt        = width_r;
    height_nxt       = height_r;
    clr_cnt_nxt      = clr_cnt_r;
    tgt_nxt          = tgt_r;
    horiz_nxt        = horiz_r;
    phase0_nxt       = phase0_r;
    above_nxt        = above_r;
    off_nxt          = off_r;
    idx_nxt          = idx_r;
    hi_nxt           = hi_r;
    res_pos_nxt      = res_pos_r;
    res_outcome_nxt  = res_outcome_r;
    out_valid_nxt    = out_valid_r;
    out_position_nxt = out_position_r;
    out_outcome_nxt  = out_outcome_r;

    if (cfg_we) begin
      unique case (cfg_index)
        bgls_pkg::CFG_SHIFT_LIMIT:  shift_limit_nxt = cfg_wdata[bgls_pkg::OFF_W-1:0];
        bgls_pkg::CFG_IMAGE_WIDTH:  width_nxt       = cfg_wdata;
        bgls_pkg::CFG_IMAGE_HEIGHT: height_nxt      = cfg_wdata;
        default: begin
        end
      endcase
    end

    if (cmd.clr_start) begin
      clr_cnt_nxt = '0;
    end else if (cmd.clr_step) begin
      clr_cnt_nxt = clr_cnt_r + 12'd1;
    end

    if (cmd.q_start) begin
      tgt_nxt    = in_target;
      horiz_nxt  = in_horizontal;
      phase0_nxt = 1'b1;
    end
    if (cmd.search_start) begin
      phase0_nxt = 1'b0;
      above_nxt  = 1'b0;
      off_nxt    = 10'd1;
    end
    if (cmd.next_above) begin
      above_nxt = 1'b1;
    end
    if (cmd.next_off) begin
      above_nxt = 1'b0;
      off_nxt   = off_r + 10'd1;
    end

    if (cmd.band_load) begin
      idx_nxt = lo[bgls_pkg::ADDR_W-1:0];
      hi_nxt  = hi[bgls_pkg::DIM_W-1:0];
    end else if (cmd.idx_step) begin
      idx_nxt = idx_r + 12'd1;
    end

    if (cmd.set_kept) begin
      res_pos_nxt     = tgt_s;
      res_outcome_nxt = bgls_pkg::OUT_KEPT;
    end
    if (cmd.set_moved) begin
      res_pos_nxt     = center;
      res_outcome_nxt = bgls_pkg::OUT_MOVED;
    end
    if (cmd.set_fail) begin
      res_pos_nxt     = tgt_s;
      res_outcome_nxt = bgls_pkg::OUT_FAIL;
    end

    if (cmd.out_load) begin
      out_valid_nxt    = 1'b1;
      out_position_nxt = res_pos_r;
      out_outcome_nxt  = res_outcome_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_limit_r <= bgls_pkg::RST_SHIFT_LIMIT;
      width_r       <= bgls_pkg::DIM_LIMIT;
      height_r      <= bgls_pkg::DIM_LIMIT;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      shift_limit_r <= shift_limit_nxt;
      width_r       <= width_nxt;
      height_r      <= height_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r          <= tgt_nxt;
    horiz_r        <= horiz_nxt;
    phase0_r       <= phase0_nxt;
    above_r        <= above_nxt;
    off_r          <= off_nxt;
    idx_r          <= idx_nxt;
    hi_r           <= hi_nxt;
    res_pos_r      <= res_pos_nxt;
    res_outcome_r  <= res_outcome_nxt;
    out_position_r <= out_position_nxt;
    out_outcome_r  <= out_outcome_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;
  assign out_outcome  = out_outcome_r;

endmodule

// ----- rtl/core/blank_gap_line_search_core.sv -----
// Top level of the blank gap line search block, joining controller and datapath.
// Pixel load requests and unused request codes are taken one per cycle while no clearing
// pass or query is in progress. A clear request, and reset itself, start a clearing pass
// over all 4096 entries of the row and column mark stores, during which no request is
// taken. A query inspects bands one at a time through the single read port of the row or
// column mark store: each band is set up in S_BAND and then read one row or column at a
// time through S_READ and S_CHECK, the scan of a band stops at its first mark, and moving
// on from a rejected band during the search goes through S_NEXT. A query result waits in
// the result register until the output register is free, and it then waits in the output
// register while further loads are accepted.
module blank_gap_line_search_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [bgls_pkg::DIM_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_req_type,
  input  logic [bgls_pkg::ADDR_W-1:0]       in_pixel_x,
  input  logic [bgls_pkg::ADDR_W-1:0]       in_pixel_y,
  input  logic [bgls_pkg::PIX_W-1:0]        in_pixel_value,
  input  logic [bgls_pkg::ADDR_W-1:0]       in_target,
  input  logic                              in_horizontal,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bgls_pkg::POS_W-1:0] out_position,
  output logic [1:0]                        out_outcome
);

  bgls_pkg::bgls_cmd_t    cmd;
  bgls_pkg::bgls_status_t status;

  bgls_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .status      (status),
    .cmd         (cmd)
  );

  bgls_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_pixel_value (in_pixel_value),
    .in_target      (in_target),
    .in_horizontal  (in_horizontal),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_position   (out_position),
    .out_outcome    (out_outcome),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

// ----- rtl/core/bgls_checker.sv -----
// Port-level assertion checker for the blank gap line search block and its bind statement.
module bgls_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_we,
  input logic [1:0]                        cfg_index,
  input logic [bgls_pkg::DIM_W-1:0]        cfg_wdata,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [1:0]                        in_req_type,
  input logic [bgls_pkg::ADDR_W-1:0]       in_pixel_x,
  input logic [bgls_pkg::ADDR_W-1:0]       in_pixel_y,
  input logic [bgls_pkg::PIX_W-1:0]        in_pixel_value,
  input logic [bgls_pkg::ADDR_W-1:0]       in_target,
  input logic                              in_horizontal,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [bgls_pkg::POS_W-1:0] out_position,
  input logic [1:0]                        out_outcome
);

  // A stalled result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_position) && $stable(out_outcome))
    else $error("stalled result changed");

  // Reset starts the clearing pass, so no request is taken right after it.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("request taken during clearing pass");

  // A query request keeps the input side busy while the search starts.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == bgls_pkg::REQ_QUERY) |=> in_stall)
    else $error("query request did not start a search");

  // A kept or failed result returns the target, which lies inside the coordinate range.
  a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome != bgls_pkg::OUT_MOVED) |-> out_position[13:12] == 2'b00)
    else $error("kept position out of range");

  // Only the three defined outcome codes are produced.
  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_outcome == bgls_pkg::OUT_KEPT) || (out_outcome == bgls_pkg::OUT_MOVED) ||
                  (out_outcome == bgls_pkg::OUT_FAIL))
    else $error("undefined outcome code");

endmodule

bind blank_gap_line_search_core bgls_checker u_bgls_checker (.*);

// ----- dv/blank_gap_line_search_core_test.sv -----
// Self-checking testbench for blank_gap_line_search_core: directed plan, then random phases.
module blank_gap_line_search_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bgls_pkg::*;

  localparam int BAND_EMPTY = 0;
  localparam int BAND_CLEAR = 1;
  localparam int BAND_INKED = 2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4200;
  localparam int DRAIN_CYCLES = 1000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 125;
  localparam int PHASES = 6;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic [1:0]              outcome;
  } line_t;

  typedef struct packed {
    logic                    is_cfg;
    logic [1:0]              req;
    logic [ADDR_W-1:0]       x;
    logic [ADDR_W-1:0]       y;
    logic [PIX_W-1:0]        val;
    logic [ADDR_W-1:0]       tgt;
    logic                    horiz;
    logic [1:0]              reg_idx;
    logic [DIM_W-1:0]        reg_val;
    logic                    typed;
    logic signed [POS_W-1:0] pos;
    logic [1:0]              outc;
  } row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [1:0]               cfg_index = CFG_SHIFT_LIMIT;
  logic [DIM_W-1:0]         cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [1:0]               in_req_type = REQ_CLEAR;
  logic [ADDR_W-1:0]        in_pixel_x = '0;
  logic [ADDR_W-1:0]        in_pixel_y = '0;
  logic [PIX_W-1:0]         in_pixel_value = '0;
  logic [ADDR_W-1:0]        in_target = '0;
  logic                     in_horizontal = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [POS_W-1:0]  out_position;
  logic [1:0]               out_outcome;

  bit    row_ink [MAX_DIM];
  bit    col_ink [MAX_DIM];
  int    max_shift = int'(RST_SHIFT_LIMIT);
  int    width_reg = MAX_DIM;
  int    height_reg = MAX_DIM;
  line_t due_lines[$];

  int   tx_pct = 19;
  int   rx_pct = 62;
  logic hold_ask = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   errors = 0;
  int   loads_n = 0;
  int   clears_n = 0;
  int   kept_n = 0;
  int   moved_n = 0;
  int   failed_n = 0;

  blank_gap_line_search_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_pixel_value(in_pixel_value),
    .in_target     (in_target),
    .in_horizontal (in_horizontal),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_position  (out_position),
    .out_outcome   (out_outcome)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("blank_gap_line_search_core_test NOT OK");
    $finish;
  end

  function automatic int dim_of(int v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  function automatic int band_of(logic horiz, int lim, int centre);
    int lo;
    int hi;
    lo = (centre - 2 < 0) ? 0 : centre - 2;
    hi = (centre + 3 > lim) ? lim : centre + 3;
    if (hi <= lo) return BAND_EMPTY;
    for (int i = lo; i < hi; i++) begin
      if (horiz ? row_ink[i] : col_ink[i]) return BAND_INKED;
    end
    return BAND_CLEAR;
  endfunction

  function automatic line_t find_line(logic [ADDR_W-1:0] tgt, logic horiz);
    line_t res;
    int    t;
    int    lim;
    t = int'(tgt);
    lim = horiz ? dim_of(height_reg) : dim_of(width_reg);
    res.position = POS_W'(t);
    res.outcome = OUT_KEPT;
    if (band_of(horiz, lim, t) == BAND_INKED) begin
      res.outcome = OUT_FAIL;
      for (int off = 1; off <= max_shift && res.outcome == OUT_FAIL; off++) begin
        if (band_of(horiz, lim, t - off) == BAND_CLEAR) begin
          res.position = POS_W'(t - off);
          res.outcome = OUT_MOVED;
        end else if (band_of(horiz, lim, t + off) == BAND_CLEAR) begin
          res.position = POS_W'(t + off);
          res.outcome = OUT_MOVED;
        end
      end
    end
    return res;
  endfunction

  function automatic row_t req_row(logic [1:0] req, logic [ADDR_W-1:0] x, logic [ADDR_W-1:0] y,
                                   logic [PIX_W-1:0] val, logic [ADDR_W-1:0] tgt,
                                   logic horiz);
    row_t r;
    r = '0;
    r.req = req;
    r.x = x;
    r.y = y;
    r.val = val;
    r.tgt = tgt;
    r.horiz = horiz;
    return r;
  endfunction

  function automatic row_t query_row(logic [ADDR_W-1:0] tgt, logic horiz, logic typed, int pos,
                                     logic [1:0] outc);
    row_t r;
    r = req_row(REQ_QUERY, '0, '0, '0, tgt, horiz);
    r.typed = typed;
    r.pos = POS_W'(pos);
    r.outc = outc;
    return r;
  endfunction

  function automatic row_t reg_row(logic [1:0] idx, int val);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = DIM_W'(val);
    return r;
  endfunction

  task automatic note_request(row_t r);
    line_t want;
    case (r.req)
      REQ_CLEAR: begin
        for (int i = 0; i < MAX_DIM; i++) begin
          row_ink[i] = 1'b0;
          col_ink[i] = 1'b0;
        end
        clears_n++;
      end
      REQ_LOAD: begin
        if (r.val == INK_VALUE && int'(r.x) < dim_of(width_reg)
            && int'(r.y) < dim_of(height_reg)) begin
          row_ink[r.y] = 1'b1;
          col_ink[r.x] = 1'b1;
        end
        loads_n++;
      end
      REQ_QUERY: begin
        if (r.typed) begin
          want.position = r.pos;
          want.outcome = r.outc;
        end else begin
          want = find_line(r.tgt, r.horiz);
        end
        due_lines.push_back(want);
      end
      default: ;
    endcase
  endtask

  task automatic pace();
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic offer(row_t r);
    in_valid <= 1'b1;
    in_req_type <= r.req;
    in_pixel_x <= r.x;
    in_pixel_y <= r.y;
    in_pixel_value <= r.val;
    in_target <= r.tgt;
    in_horizontal <= r.horiz;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    note_request(r);
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(logic [1:0] idx, logic [DIM_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SHIFT_LIMIT:  max_shift = int'(val[OFF_W-1:0]);
      CFG_IMAGE_WIDTH:  width_reg = int'(val);
      CFG_IMAGE_HEIGHT: height_reg = int'(val);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ask && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_pct);
    end
  end

  always @(negedge clk) begin : check_result
    line_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_lines.size() == 0) begin
        errors++;
        $error("result with no pending query: position %0d outcome %0d",
               out_position, out_outcome);
      end else begin
        want = due_lines.pop_front();
        if (out_position !== want.position) begin
          errors++;
          $error("position: expected %0d, got %0d", want.position, out_position);
        end
        if (out_outcome !== want.outcome) begin
          errors++;
          $error("outcome: expected %0d, got %0d", want.outcome, out_outcome);
        end
        case (want.outcome)
          OUT_KEPT:  kept_n++;
          OUT_MOVED: moved_n++;
          default:   failed_n++;
        endcase
      end
    end
  end

  initial begin : stimulus
    row_t plan[$];
    row_t item;
    int   max_v;
    int   w_v;
    int   h_v;
    int   qpct;
    int   span_w;
    int   span_h;
    int   xbase;
    int   ybase;
    int   pick;
    int   t;
    int   sent;

    plan.push_back(query_row(0, 1'b1, 1'b1, 0, OUT_KEPT));
    plan.push_back(query_row(ADDR_LAST, 1'b0, 1'b1, 4095, OUT_KEPT));
    plan.push_back(req_row(REQ_UNUSED, ADDR_LAST, ADDR_LAST, 8'hFF, ADDR_LAST, 1'b1));
    plan.push_back(req_row(REQ_LOAD, ADDR_LAST, ADDR_LAST, INK_VALUE, '0, 1'b0));
    plan.push_back(req_row(REQ_LOAD, 10, 10, 8'd254, '0, 1'b0));
    plan.push_back(req_row(REQ_LOAD, 0, 0, INK_VALUE, '0, 1'b0));
    plan.push_back(query_row(10, 1'b1, 1'b1, 10, OUT_KEPT));
    plan.push_back(query_row(0, 1'b1, 1'b0, 0, OUT_KEPT));
    plan.push_back(query_row(ADDR_LAST, 1'b0, 1'b0, 0, OUT_KEPT));
    plan.push_back(reg_row(CFG_SHIFT_LIMIT, 0));
    plan.push_back(query_row(0, 1'b0, 1'b1, 0, OUT_FAIL));
    plan.push_back(reg_row(CFG_IMAGE_WIDTH, 100));
    plan.push_back(reg_row(CFG_IMAGE_HEIGHT, 13'h1FFF));
    plan.push_back(req_row(REQ_LOAD, 100, 5, INK_VALUE, '0, 1'b0));
    plan.push_back(req_row(REQ_LOAD, 99, ADDR_LAST, INK_VALUE, '0, 1'b0));
    plan.push_back(query_row(5, 1'b1, 1'b1, 5, OUT_KEPT));
    plan.push_back(query_row(ADDR_LAST, 1'b1, 1'b1, 4095, OUT_FAIL));
    plan.push_back(query_row(100, 1'b0, 1'b1, 100, OUT_FAIL));
    plan.push_back(reg_row(CFG_IMAGE_WIDTH, 0));
    plan.push_back(query_row(0, 1'b0, 1'b1, 0, OUT_KEPT));
    plan.push_back(req_row(REQ_LOAD, 0, 7, INK_VALUE, '0, 1'b0));
    plan.push_back(reg_row(CFG_IMAGE_WIDTH, MAX_DIM));
    plan.push_back(reg_row(CFG_SHIFT_LIMIT, 1023));
    plan.push_back(query_row(100, 1'b0, 1'b0, 0, OUT_KEPT));
    plan.push_back(query_row(7, 1'b1, 1'b1, 7, OUT_KEPT));
    plan.push_back(req_row(REQ_CLEAR, '0, '0, '0, '0, 1'b0));
    plan.push_back(query_row(0, 1'b1, 1'b1, 0, OUT_KEPT));
    plan.push_back(req_row(REQ_LOAD, ADDR_LAST, 0, INK_VALUE, '0, 1'b0));
    plan.push_back(query_row(ADDR_LAST, 1'b0, 1'b0, 0, OUT_KEPT));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        put_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        pace();
        offer(plan[i]);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin max_v = 20;   w_v = 4096; h_v = 4096; qpct = 25; end
        1:       begin max_v = 3;    w_v = 200;  h_v = 37;   qpct = 25; end
        2:       begin max_v = 1023; w_v = 40;   h_v = 8191; qpct = 8;  end
        3:       begin max_v = 0;    w_v = 4096; h_v = 1;    qpct = 25; end
        4:       begin max_v = 7;    w_v = 8191; h_v = 4096; qpct = 40; end
        default: begin max_v = 12;   w_v = 0;    h_v = 300;  qpct = 25; end
      endcase
      settle();
      put_reg(CFG_SHIFT_LIMIT, DIM_W'(max_v));
      put_reg(CFG_IMAGE_WIDTH, DIM_W'(w_v));
      put_reg(CFG_IMAGE_HEIGHT, DIM_W'(h_v));
      if (ph < 2) begin
        tx_pct = 19;
        rx_pct <= 62;
      end else if (ph < 4) begin
        tx_pct = 62;
        rx_pct <= 19;
      end else begin
        tx_pct = 0;
        rx_pct <= 0;
      end
      if (ph == 4) hold_ask <= 1'b1;
      span_w = (dim_of(w_v) > 24) ? dim_of(w_v) - 24 : 0;
      span_h = (dim_of(h_v) > 24) ? dim_of(h_v) - 24 : 0;
      xbase = $urandom_range(span_w);
      ybase = $urandom_range(span_h);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(29) == 0) begin
          xbase = $urandom_range(span_w);
          ybase = $urandom_range(span_h);
        end
        pick = $urandom_range(99);
        if (pick < 2) begin
          item = req_row(REQ_CLEAR, ADDR_W'($urandom_range(ADDR_LAST)),
                         ADDR_W'($urandom_range(ADDR_LAST)), PIX_W'($urandom_range(255)),
                         ADDR_W'($urandom_range(ADDR_LAST)), 1'($urandom_range(1)));
        end else if (pick < 4) begin
          item = req_row(REQ_UNUSED, ADDR_W'($urandom_range(ADDR_LAST)),
                         ADDR_W'($urandom_range(ADDR_LAST)), PIX_W'($urandom_range(255)),
                         ADDR_W'($urandom_range(ADDR_LAST)), 1'($urandom_range(1)));
        end else if (pick < 4 + qpct) begin
          item = query_row('0, 1'($urandom_range(1)), 1'b0, 0, OUT_KEPT);
          if ($urandom_range(9) == 0) begin
            item.tgt = ADDR_W'($urandom_range(ADDR_LAST));
          end else begin
            t = (item.horiz ? ybase : xbase) + $urandom_range(28) - 2;
            item.tgt = ADDR_W'((t < 0) ? 0 : (t > int'(ADDR_LAST)) ? int'(ADDR_LAST) : t);
          end
        end else if ($urandom_range(99) < 85) begin
          item = req_row(REQ_LOAD, ADDR_W'(xbase + $urandom_range(23)),
                         ADDR_W'(ybase + $urandom_range(23)),
                         ($urandom_range(9) == 0) ? PIX_W'($urandom_range(255)) : INK_VALUE,
                         ADDR_W'($urandom_range(ADDR_LAST)), 1'($urandom_range(1)));
        end else begin
          item = req_row(REQ_LOAD, ADDR_W'($urandom_range(ADDR_LAST)),
                         ADDR_W'($urandom_range(ADDR_LAST)), PIX_W'($urandom_range(255)),
                         ADDR_W'($urandom_range(ADDR_LAST)), 1'($urandom_range(1)));
        end
        if (item.req != REQ_UNUSED) sent++;
        pace();
        offer(item);
      end
    end

    in_valid <= 1'b0;
    while (due_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d query results (%0d kept, %0d moved, %0d not found) among %0d loads",
             kept_n + moved_n + failed_n, kept_n, moved_n, failed_n, loads_n);
    $display("and %0d clears, under the reset setting and %0d register settings.",
             clears_n, PHASES);
    if (errors == 0) begin
      $display("blank_gap_line_search_core_test OK");
    end else begin
      $display("blank_gap_line_search_core_test NOT OK");
    end
    $finish;
  end

endmodule
